// ===== hw/rtl/pmrb_pkg.sv =====
package pmrb_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [3:0] CFG_ORIGIN_X  = 4'd0;
  localparam logic [3:0] CFG_ORIGIN_Y  = 4'd1;
  localparam logic [3:0] CFG_BOX_MIN_X = 4'd2;
  localparam logic [3:0] CFG_BOX_MAX_X = 4'd3;
  localparam logic [3:0] CFG_BOX_MIN_Y = 4'd4;
  localparam logic [3:0] CFG_BOX_MAX_Y = 4'd5;
  localparam logic [3:0] CFG_RANGE_FLR = 4'd6;
  localparam logic [3:0] CFG_RANGE_CEIL = 4'd7;

  localparam int CORDIC_STEPS = 24;

  // binary angle steps, 2^32 units per turn
  localparam logic [31:0] ANGLE_STEP [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic [9:0]         read_index;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [9:0]  bin_index;
    logic [23:0] bin_range;
    logic        bin_empty;
  } out_t;

endpackage

// ===== hw/rtl/pmrb_bin_mem.sv =====
module pmrb_bin_mem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [24:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [24:0]   rd_data
);

  // bit 24 is the filled flag, bits 23:0 the minimum range
  logic [24:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/pmrb_cordic.sv =====
module pmrb_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [24:0] dx,
  input  logic signed [24:0] dy,
  output logic               done,
  output logic signed [33:0] angle
);

  logic signed [33:0] x_r, y_r, z_r;
  logic signed [33:0] x0, y0, z0, xs, ys;
  logic [4:0]         cnt_r;
  logic               run_r;

  // scale by 64, fold the left half plane by a quarter turn
  always_comb begin
    x0 = {{3{dx[24]}}, dx, 6'd0};
    y0 = {{3{dy[24]}}, dy, 6'd0};
    z0 = '0;
    if (dx[24]) begin
      if (!dy[24]) begin
        x0 = {{3{dy[24]}}, dy, 6'd0};
        y0 = -{{3{dx[24]}}, dx, 6'd0};
        z0 = 34'sh040000000;
      end else begin
        x0 = -{{3{dy[24]}}, dy, 6'd0};
        y0 = {{3{dx[24]}}, dx, 6'd0};
        z0 = -34'sh040000000;
      end
    end
    xs = x_r >>> cnt_r;
    ys = y_r >>> cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
    end else if (run_r) begin
      if (!y_r[33]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + 34'(pmrb_pkg::ANGLE_STEP[cnt_r]);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - 34'(pmrb_pkg::ANGLE_STEP[cnt_r]);
      end
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(pmrb_pkg::CORDIC_STEPS - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  assign done  = !run_r;
  assign angle = z_r;

endmodule

// ===== hw/rtl/pmrb_isqrt.sv =====
module pmrb_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [49:0] value,
  output logic        done,
  output logic [24:0] root
);

  logic [49:0] v_r;
  logic [27:0] rem_r, rem_sh, trial;
  logic [24:0] root_r;
  logic [4:0]  cnt_r;
  logic        run_r;

  always_comb begin
    rem_sh = {rem_r[25:0], v_r[49:48]};
    trial  = {1'b0, root_r, 2'b01};
  end

  // two bits of the radicand a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      cnt_r  <= '0;
      v_r    <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      v_r <= {v_r[47:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[23:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[23:0], 1'b0};
      end
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd24) begin
        run_r <= 1'b0;
      end
    end
  end

  assign done = !run_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/polar_min_range_binner.sv =====
// Add point: the CORDIC angle unit (24 steps) and the radix-4 root unit (25 steps) set the
//   time from the start transfer to the result strobe.
// Read bin: one memory read. Clear: one bin a cycle.
// One item at a time: busy stays high until the result strobe; the receiver never stalls.
// Reset (synchronous, active low) loads the register defaults and starts a
//   clearing sweep of the bin memory; busy is high during it.
module polar_min_range_binner #(
  parameter int BINS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pmrb_pkg::in_t     in_data,
  output logic              out_valid,
  output pmrb_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SQ, S_CHK, S_ITER, S_BIN, S_RD, S_WR, S_RDO
  } state_t;

  state_t st_r;

  // configuration registers
  logic signed [23:0] org_x_r, org_y_r, min_x_r, max_x_r, min_y_r, max_y_r;
  logic [23:0]        flr_r, ceil_r;

  // per-item working registers
  logic signed [24:0] dx_r, dy_r;
  logic [48:0]        sqx_r, sqy_r;
  logic [47:0]        flsq_r, clsq_r;
  logic [BW-1:0]      bin_r, clr_cnt_r;
  logic [23:0]        rng_r;
  logic               clr_out_r, rd_ok_r;
  logic [9:0]         ridx_r;
  logic               out_valid_r;
  pmrb_pkg::out_t     out_r;

  logic signed [49:0] prod_x, prod_y;
  logic [49:0]        sum_sq;
  logic               pass;
  logic               unit_start;
  logic               cor_done, sq_done;
  logic signed [33:0] angle;
  logic [24:0]        root;
  logic signed [34:0] u_ang;
  logic [33:0]        u_clip;
  logic [46:0]        u_prod;
  logic [14:0]        bin_wide;
  logic [BW-1:0]      bin_nxt;
  logic [12:0]        ridx_ext, bin_ext;
  logic               mem_we;
  logic [BW-1:0]      mem_wa, mem_ra;
  logic [24:0]        mem_wd, mem_rd;

  assign cfg_ready = 1'b1;
  assign busy      = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      min_x_r <= -24'sd10000;
      max_x_r <= 24'sd10000;
      min_y_r <= -24'sd10000;
      max_y_r <= 24'sd10000;
      flr_r   <= 24'd50;
      ceil_r  <= 24'd10000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmrb_pkg::CFG_ORIGIN_X:   org_x_r <= cfg_data;
        pmrb_pkg::CFG_ORIGIN_Y:   org_y_r <= cfg_data;
        pmrb_pkg::CFG_BOX_MIN_X:  min_x_r <= cfg_data;
        pmrb_pkg::CFG_BOX_MAX_X:  max_x_r <= cfg_data;
        pmrb_pkg::CFG_BOX_MIN_Y:  min_y_r <= cfg_data;
        pmrb_pkg::CFG_BOX_MAX_Y:  max_y_r <= cfg_data;
        pmrb_pkg::CFG_RANGE_FLR:  flr_r   <= cfg_data;
        pmrb_pkg::CFG_RANGE_CEIL: ceil_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    prod_x = dx_r * dx_r;
    prod_y = dy_r * dy_r;
    sum_sq = 50'(sqx_r) + 50'(sqy_r);
    // every limit is exclusive; range compared squared, so exact
    pass = (dx_r > 25'(min_x_r)) && (dx_r < 25'(max_x_r)) &&
           (dy_r > 25'(min_y_r)) && (dy_r < 25'(max_y_r)) &&
           (sum_sq > 50'(flsq_r)) && (sum_sq < 50'(clsq_r));
    unit_start = (st_r == S_CHK) && pass;

    // shift the angle to [0, 2^32), scale to bins, clamp +pi to the last bin
    u_ang    = {angle[33], angle} + 35'sh080000000;
    u_clip   = u_ang[34] ? '0 : u_ang[33:0];
    u_prod   = 47'(u_clip) * 47'(BINS);
    bin_wide = u_prod[46:32];
    bin_nxt  = (bin_wide >= 15'(BINS)) ? BW'(BINS - 1) : bin_wide[BW-1:0];

    ridx_ext = 13'(in_data.read_index);
    bin_ext  = 13'(bin_r);
  end

  // memory port control: sweep on clear, read-modify-write on add, plain read on read
  always_comb begin
    mem_we = 1'b0;
    mem_wa = bin_r;
    mem_wd = {1'b1, rng_r};
    mem_ra = (st_r == S_IDLE) ? ridx_ext[BW-1:0] : bin_r;
    if (st_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
    end else if (st_r == S_WR) begin
      mem_we = !mem_rd[24] || (rng_r < mem_rd[23:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_cnt_r   <= '0;
      clr_out_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == BW'(BINS - 1)) begin
            st_r <= S_IDLE;
            if (clr_out_r) begin
              out_valid_r <= 1'b1;
              out_r       <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (in_data.op)
              pmrb_pkg::OP_CLEAR: begin
                clr_cnt_r <= '0;
                clr_out_r <= 1'b1;
                st_r      <= S_CLR;
              end
              pmrb_pkg::OP_ADD: begin
                dx_r <= {in_data.point_x[23], in_data.point_x} - {org_x_r[23], org_x_r};
                dy_r <= {in_data.point_y[23], in_data.point_y} - {org_y_r[23], org_y_r};
                st_r <= S_SQ;
              end
              pmrb_pkg::OP_READ: begin
                ridx_r  <= in_data.read_index;
                rd_ok_r <= (ridx_ext < 13'(BINS));
                st_r    <= S_RDO;
              end
              default: begin
                // unused op: answer with all fields zero
                out_valid_r <= 1'b1;
                out_r       <= '0;
              end
            endcase
          end
        end
        S_SQ: begin
          sqx_r  <= prod_x[48:0];
          sqy_r  <= prod_y[48:0];
          flsq_r <= flr_r * flr_r;
          clsq_r <= ceil_r * ceil_r;
          st_r   <= S_CHK;
        end
        S_CHK: begin
          if (pass) begin
            st_r <= S_ITER;
          end else begin
            out_valid_r <= 1'b1;
            out_r       <= '0;
            st_r        <= S_IDLE;
          end
        end
        S_ITER: begin
          if (cor_done && sq_done) begin
            st_r <= S_BIN;
          end
        end
        S_BIN: begin
          bin_r <= bin_nxt;
          rng_r <= root[24] ? 24'hFFFFFF : root[23:0];
          st_r  <= S_RD;
        end
        S_RD: begin
          st_r <= S_WR;
        end
        S_WR: begin
          out_valid_r <= 1'b1;
          // accepted, bin index, no range, not empty
          out_r       <= {1'b1, bin_ext[9:0], 24'd0, 1'b0};
          st_r        <= S_IDLE;
        end
        S_RDO: begin
          out_valid_r     <= 1'b1;
          out_r.accepted  <= 1'b0;
          out_r.bin_index <= ridx_r;
          if (rd_ok_r && mem_rd[24]) begin
            out_r.bin_range <= mem_rd[23:0];
            out_r.bin_empty <= 1'b0;
          end else begin
            out_r.bin_range <= '0;
            out_r.bin_empty <= 1'b1;
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  pmrb_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .done  (cor_done),
    .angle (angle)
  );

  pmrb_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .value (sum_sq),
    .done  (sq_done),
    .root  (root)
  );

  pmrb_bin_mem #(
    .DEPTH (BINS),
    .AW    (BW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // an accepted point always reports a non-empty result slot
  a_acc_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.bin_empty && out_data.bin_range == '0)
    else $error("accepted point with read fields set");

  // the write-back stage always ends in a result strobe
  a_wr_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WR |=> out_valid && out_data.accepted)
    else $error("write-back without result");

  // both iterative units are idle whenever a new add is started
  a_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
    unit_start |-> cor_done && sq_done)
    else $error("unit restarted while running");

  // reset always begins the clearing sweep
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("no clearing sweep after reset");

endmodule
